@@ src/md5_pkg.sv @@
// md5 package: shared types, constants and round tables
package md5_pkg;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	// request from front to back: compress a block or emit the digest
	typedef enum logic [1:0] {
		OP_BLOCK  = 2'd0,
		OP_FINAL  = 2'd1
	} op_t;

	typedef struct packed {
		op_t          op;
		logic         buf_sel;
	} cmd_t;

	typedef enum logic [2:0] {
		FR_IDLE   = 3'd0,
		FR_PAD    = 3'd1,
		FR_LEN    = 3'd2,
		FR_PUSH   = 3'd3,
		FR_WAIT   = 3'd4
	} fr_state_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'd0,
		BK_ROUND = 2'd1,
		BK_ADD   = 2'd2,
		BK_OUT   = 2'd3
	} bk_state_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amt(input logic [5:0] i);
		logic [4:0] r;
		case ({i[5:4], i[1:0]})
			4'd0: r = 5'd7;  4'd1: r = 5'd12; 4'd2: r = 5'd17; 4'd3: r = 5'd22;
			4'd4: r = 5'd5;  4'd5: r = 5'd9;  4'd6: r = 5'd14; 4'd7: r = 5'd20;
			4'd8: r = 5'd4;  4'd9: r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
			4'd12: r = 5'd6; 4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
		endcase
		return r;
	endfunction

	// message word index used by round i
	function automatic logic [3:0] word_idx(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
			2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
			default: g = 4'(i[3:0] * 4'd7);
		endcase
		return g;
	endfunction

endpackage

@@ src/md5_cmd_fifo.sv @@
// md5 command queue between the byte front and the compression back
module md5_cmd_fifo
	import md5_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic not_empty,
	output logic not_full,
	output cmd_t head_cmd
);
	cmd_t       ent_q [4];
	logic [2:0] wp_q;
	logic [2:0] rp_q;

	assign not_empty = wp_q != rp_q;
	assign not_full  = (wp_q - rp_q) != 3'd4;
	assign head_cmd  = ent_q[rp_q[1:0]];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q[1:0]] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 3'd1;
			if (pop)  rp_q <= rp_q + 3'd1;
		end
	end
endmodule

@@ src/md5_front.sv @@
// md5 front: byte packing into two block buffers, padding and length
module md5_front
	import md5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	input  logic        in_valid,
	output logic        in_stall,
	// queue side
	output logic        cmd_push,
	output cmd_t        cmd_out,
	input  logic        cmd_room,
	// buffer release from the back
	input  logic        buf_free,
	input  logic        free_sel,
	// word read port for the back
	input  logic        rd_sel,
	input  logic [3:0]  rd_word,
	output logic [31:0] rd_data
);
	// each buffer holds sixteen little-endian words, written a byte lane at a time
	logic [31:0] mem0 [16];
	logic [31:0] mem1 [16];
	logic [1:0]  busy_q;
	logic        wsel_q;
	logic [60:0] cnt_q;
	logic [5:0]  ppos_q;
	logic [2:0]  lidx_q;
	logic [1:0]  pend_q;
	fr_state_t   st_q, st_d;
	logic        need2_q;

	logic        acc;
	logic        wr_en;
	logic [5:0]  wr_adr;
	logic [7:0]  wr_dat;
	logic [63:0] bits;
	logic        blk_full;
	logic        seal;
	logic [1:0]  busy_set;
	logic [1:0]  busy_clr;

	assign bits = {cnt_q, 3'b000};
	assign acc  = in_valid && !in_stall;

	// accept only in idle with a free buffer and room for the worst case
	assign in_stall = (st_q != FR_IDLE) || busy_q[wsel_q] || !cmd_room;

	assign blk_full = acc && byte_present && (cnt_q[5:0] == 6'd63);

	// a block command hands the write buffer to the back
	assign seal     = cmd_push && (cmd_out.op == OP_BLOCK);
	assign busy_set = seal ? (2'b01 << wsel_q) : 2'b00;
	assign busy_clr = buf_free ? (2'b01 << free_sel) : 2'b00;

	always_comb begin
		st_d = st_q;
		case (st_q)
			FR_IDLE: if (acc && end_of_message) st_d = FR_WAIT;
			FR_WAIT: if (!busy_q[wsel_q]) st_d = FR_PAD;
			FR_PAD: begin
				// last byte of a first pad block: wait for the other buffer
				if (ppos_q == 6'd63) st_d = FR_WAIT;
				else if (!need2_q && ppos_q == 6'd55) st_d = FR_LEN;
			end
			FR_LEN:  if (lidx_q == 3'd7) st_d = FR_PUSH;
			FR_PUSH: if (cmd_room) st_d = FR_IDLE;
			default: st_d = FR_IDLE;
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_adr = cnt_q[5:0];
		wr_dat = data_byte;
		cmd_push = 1'b0;
		cmd_out.op = OP_BLOCK;
		cmd_out.buf_sel = wsel_q;
		case (st_q)
			FR_IDLE: begin
				wr_en = acc && byte_present;
				cmd_push = blk_full;
			end
			FR_PAD: begin
				wr_en = 1'b1;
				wr_adr = ppos_q;
				wr_dat = (pend_q == 2'd1) ? PAD_BYTE : 8'h00;
				cmd_push = (ppos_q == 6'd63);
			end
			FR_LEN: begin
				wr_en = 1'b1;
				wr_adr = {3'b111, lidx_q};
				wr_dat = bits[{lidx_q, 3'b000} +: 8];
				cmd_push = (lidx_q == 3'd7);
			end
			FR_PUSH: begin
				cmd_push = cmd_room;
				cmd_out.op = OP_FINAL;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en && !wsel_q) mem0[wr_adr[5:2]][{wr_adr[1:0], 3'b000} +: 8] <= wr_dat;
		if (wr_en && wsel_q)  mem1[wr_adr[5:2]][{wr_adr[1:0], 3'b000} +: 8] <= wr_dat;
	end

	assign rd_data = rd_sel ? mem1[rd_word] : mem0[rd_word];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FR_IDLE;
			busy_q <= '0;
			wsel_q <= 1'b0;
			cnt_q <= '0;
			ppos_q <= '0;
			lidx_q <= '0;
			pend_q <= '0;
			need2_q <= 1'b0;
		end else begin
			st_q <= st_d;
			busy_q <= (busy_q & ~busy_clr) | busy_set;
			if (seal) wsel_q <= !wsel_q;
			case (st_q)
				FR_IDLE: begin
					if (acc && byte_present) cnt_q <= cnt_q + 61'd1;
					if (acc && end_of_message) begin
						// pad starts at the position after any byte taken now
						ppos_q <= cnt_q[5:0] + {5'd0, byte_present};
						pend_q <= 2'd1;
						need2_q <= ((cnt_q[5:0] + {5'd0, byte_present}) >= 6'd56);
					end
				end
				FR_WAIT: if (!busy_q[wsel_q]) pend_q <= pend_q;
				FR_PAD: begin
					pend_q <= 2'd2;
					ppos_q <= ppos_q + 6'd1;
					if (ppos_q == 6'd63) need2_q <= 1'b0;
					if (!need2_q && ppos_q == 6'd55) lidx_q <= '0;
				end
				FR_LEN: lidx_q <= lidx_q + 3'd1;
				FR_PUSH: if (cmd_room) cnt_q <= '0;
				default: ;
			endcase
		end
	end
endmodule

@@ src/md5_back.sv @@
// md5 back: one round per cycle compression and digest output
module md5_back
	import md5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_avail,
	input  cmd_t        cmd_in,
	output logic        cmd_pop,
	output logic        buf_free,
	output logic        free_sel,
	output logic        rd_sel,
	output logic [3:0]  rd_word,
	input  logic [31:0] rd_data,
	output logic [31:0] digest_word,
	output logic        last_word,
	output logic        out_valid,
	input  logic        out_stall
);
	bk_state_t   st_q, st_d;
	logic [31:0] ch_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  rnd_q;
	logic        sel_q;
	logic [1:0]  oidx_q;
	logic [31:0] f, t, tr;
	logic        fire;

	assign rd_sel  = sel_q;
	assign rd_word = word_idx(rnd_q);

	always_comb begin
		case (rnd_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		t  = f + a_q + round_k(rnd_q) + rd_data;
		tr = (t << rot_amt(rnd_q)) | (t >> (6'd32 - {1'b0, rot_amt(rnd_q)}));
	end

	assign fire = out_valid && !out_stall;

	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE: if (cmd_avail) st_d = (cmd_in.op == OP_FINAL) ? BK_OUT : BK_ROUND;
			BK_ROUND: if (rnd_q == 6'd63) st_d = BK_ADD;
			BK_ADD: st_d = BK_IDLE;
			BK_OUT: if (fire && oidx_q == 2'd3) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = 1'b0;
		buf_free = 1'b0;
		out_valid = 1'b0;
		case (st_q)
			BK_IDLE: cmd_pop = cmd_avail && (cmd_in.op == OP_BLOCK);
			BK_ADD: buf_free = 1'b1;
			BK_OUT: begin
				out_valid = 1'b1;
				cmd_pop = fire && oidx_q == 2'd3;
			end
			default: ;
		endcase
	end
	assign free_sel = sel_q;
	assign digest_word = ch_q[oidx_q];
	assign last_word = oidx_q == 2'd3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			ch_q[0] <= IV_A; ch_q[1] <= IV_B; ch_q[2] <= IV_C; ch_q[3] <= IV_D;
			rnd_q <= '0;
			sel_q <= 1'b0;
			oidx_q <= '0;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
		end else begin
			st_q <= st_d;
			case (st_q)
				BK_IDLE: if (cmd_avail && cmd_in.op == OP_BLOCK) begin
					sel_q <= cmd_in.buf_sel;
					rnd_q <= '0;
					a_q <= ch_q[0]; b_q <= ch_q[1]; c_q <= ch_q[2]; d_q <= ch_q[3];
				end
				BK_ROUND: begin
					a_q <= d_q; d_q <= c_q; c_q <= b_q;
					b_q <= b_q + tr;
					rnd_q <= rnd_q + 6'd1;
				end
				BK_ADD: begin
					ch_q[0] <= ch_q[0] + a_q; ch_q[1] <= ch_q[1] + b_q;
					ch_q[2] <= ch_q[2] + c_q; ch_q[3] <= ch_q[3] + d_q;
				end
				BK_OUT: if (fire) begin
					oidx_q <= oidx_q + 2'd1;
					if (oidx_q == 2'd3) begin
						ch_q[0] <= IV_A; ch_q[1] <= IV_B; ch_q[2] <= IV_C; ch_q[3] <= IV_D;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

@@ src/md5_hash_engine.sv @@
// md5 hash engine top level: front, command queue and compression back
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | data_byte, byte_present, end_of_message
//  out     | out_valid | out_stall | digest_word, last_word
// a byte is taken per cycle while idle with a free block buffer and queue room; two buffers alternate
// a block is loaded in the back, run through 64 rounds at one per cycle, then added to the chain
// end of message writes padding and length, after any wait for a free buffer,
// then four digest words follow
// reset returns the chaining words to the initial values and empties the queue
module md5_hash_engine
	import md5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic        last_word
);
	logic        push, pop, avail, room, bfree, fsel, rsel;
	cmd_t        pcmd, hcmd;
	logic [3:0]  rword;
	logic [31:0] rdata;

	md5_front u_front (
		.clk, .arst_n, .data_byte, .byte_present, .end_of_message,
		.in_valid, .in_stall,
		.cmd_push(push), .cmd_out(pcmd), .cmd_room(room),
		.buf_free(bfree), .free_sel(fsel),
		.rd_sel(rsel), .rd_word(rword), .rd_data(rdata)
	);

	md5_cmd_fifo u_fifo (
		.clk, .arst_n, .push, .push_cmd(pcmd), .pop,
		.not_empty(avail), .not_full(room), .head_cmd(hcmd)
	);

	md5_back u_back (
		.clk, .arst_n, .cmd_avail(avail), .cmd_in(hcmd), .cmd_pop(pop),
		.buf_free(bfree), .free_sel(fsel), .rd_sel(rsel), .rd_word(rword),
		.rd_data(rdata), .digest_word, .last_word, .out_valid, .out_stall
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room) else $error("push into full queue");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> avail) else $error("pop from empty queue");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digest_word))
		else $error("digest changed under stall");
endmodule

@@ tb/md5_hash_engine_tb.sv @@
// testbench for the streaming md5 engine: directed and random messages checked against an md5 model
`timescale 1ns / 1ps

class md5_digest_board;
	logic [31:0] chain[4];
	logic [7:0]  blk[64];
	logic [60:0] msg_len;
	logic [32:0] pending_words[$];
	int          errors;
	int          digests_checked;

	function new();
		errors = 0;
		digests_checked = 0;
		restart();
	endfunction

	function void restart();
		chain[0] = md5_pkg::IV_A;
		chain[1] = md5_pkg::IV_B;
		chain[2] = md5_pkg::IV_C;
		chain[3] = md5_pkg::IV_D;
		msg_len = '0;
	endfunction

	function void compress();
		logic [31:0] w[16];
		logic [31:0] a, b, c, d, f, t, r;
		int g, stage;
		int sh[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
		logic [31:0] kt[64] = '{
			32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf,
			32'h4787c62a, 32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af,
			32'hffff5bb1, 32'h895cd7be, 32'h6b901122, 32'hfd987193, 32'ha679438e,
			32'h49b40821, 32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
			32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8, 32'h21e1cde6,
			32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
			32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122,
			32'hfde5380c, 32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
			32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05, 32'hd9d4d039,
			32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665, 32'hf4292244, 32'h432aff97,
			32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d,
			32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
			32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		for (int i = 0; i < 64; i++) begin
			stage = i / 16;
			case (stage)
				0: begin f = (b & c) | (~b & d); g = i; end
				1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
				2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
				default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
			endcase
			t = f + a + kt[i] + w[g];
			r = (t << sh[stage * 4 + i % 4]) | (t >> (32 - sh[stage * 4 + i % 4]));
			a = d; d = c; c = b;
			b = b + r;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
	endfunction

	// note one accepted request
	function void note_request(logic [7:0] data, logic has_byte, logic eom);
		int pos;
		logic [63:0] bits;
		if (has_byte) begin
			blk[msg_len[5:0]] = data;
			msg_len++;
			if (msg_len[5:0] == 0)
				compress();
		end
		if (!eom)
			return;
		pos = msg_len[5:0];
		bits = {msg_len, 3'b000};
		blk[pos] = md5_pkg::PAD_BYTE;
		for (int i = pos + 1; i < 64; i++)
			blk[i] = 8'h00;
		if (pos >= 56) begin
			compress();
			for (int i = 0; i < 64; i++)
				blk[i] = 8'h00;
		end
		for (int i = 0; i < 8; i++)
			blk[56 + i] = bits[8*i +: 8];
		compress();
		for (int i = 0; i < 4; i++)
			pending_words.insert(pending_words.size(), {i == 3, chain[i]});
		restart();
	endfunction

	function void check_word(logic [31:0] word, logic last);
		logic [32:0] exp_w;
		if (pending_words.size() == 0) begin
			$display("%0t: unexpected digest word %h last %b", $time, word, last);
			errors++;
			return;
		end
		exp_w = pending_words.pop_front();
		if (word !== exp_w[31:0]) begin
			$display("%0t: digest_word expected %h actual %h", $time, exp_w[31:0], word);
			errors++;
		end
		if (last !== exp_w[32]) begin
			$display("%0t: last_word expected %b actual %b", $time, exp_w[32], last);
			errors++;
		end
		if (exp_w[32])
			digests_checked++;
	endfunction
endclass

module md5_hash_engine_tb;
	import md5_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        byte_present;
	logic        end_of_message;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic        last_word;

	md5_digest_board board;
	int          requests_sent;
	int          cycle_count;
	int          stall_mode;

	md5_hash_engine u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .byte_present(byte_present),
		.end_of_message(end_of_message),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .last_word(last_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		board = new();
		requests_sent = 0;
		in_valid = 1'b0;
		data_byte = '0;
		byte_present = 1'b0;
		end_of_message = 1'b0;
		out_stall = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver: stall pattern switches between none, light and heavy
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_word(digest_word, last_word);
		if ($urandom_range(0, 199) == 0)
			stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 2000000) begin
			$display("FAIL");
			$finish;
		end
	end

	int burst_left = 0;

	// drive one request, holding it until accepted; gaps between random bursts
	task automatic send_request(logic [7:0] data, logic has_byte, logic eom);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= data;
		byte_present <= has_byte;
		end_of_message <= eom;
		do @(posedge clk); while (in_stall);
		board.note_request(data, has_byte, eom);
		requests_sent++;
	endtask

	task automatic drive_message(int len, int mode);
		for (int i = 0; i < len; i++) begin
			// idle requests scattered in
			if ($urandom_range(0, 15) == 0)
				send_request(8'($urandom), 1'b0, 1'b0);
			case (mode)
				0: send_request(8'($urandom), 1'b1, (i == len - 1));
				1: send_request(8'h00, 1'b1, (i == len - 1));
				default: send_request(8'hff, 1'b1, (i == len - 1));
			endcase
		end
		if (len == 0)
			send_request(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic drain_digests();
		in_valid <= 1'b0;
		while (board.pending_words.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int len;
		stall_mode = 0;
		cycle_count = 0;
		@(posedge arst_n);
		@(posedge clk);
		// directed: empty message, single bytes, padding boundaries
		drive_message(0, 0);
		drive_message(1, 1);
		drive_message(1, 2);
		send_request(8'h61, 1'b0, 1'b0);
		drive_message(3, 0);
		send_request(8'h5a, 1'b1, 1'b0);
		send_request(8'h00, 1'b0, 1'b1);
		drain_digests();
		drive_message(55, 0);
		drive_message(56, 2);
		drive_message(64, 0);
		drive_message(65, 1);
		drain_digests();
		// random: mostly short messages, a few long ones
		while (requests_sent < 360) begin
			if (requests_sent < 300 && $urandom_range(0, 9) == 0)
				len = $urandom_range(64, 80);
			else
				len = $urandom_range(0, 20);
			drive_message(len, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
			if ($urandom_range(0, 5) == 0)
				drain_digests();
		end
		in_valid <= 1'b0;
		while (board.pending_words.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d requests and %0d digests", requests_sent,
			board.digests_checked);
		$display("messages included empty, 55/56/64/65-byte and multi-block cases");
		if (board.errors == 0 && board.pending_words.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
